// ===== hw/rtl/cd_pkg.sv =====
package cd_pkg;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_MIN_RADIUS   = 2'd2
    } reg_index_t;

    localparam logic [7:0] WIDTH_RESET  = 8'd100;
    localparam logic [7:0] HEIGHT_RESET = 8'd100;
    localparam logic [5:0] MIN_R_RESET  = 6'd5;

    typedef struct packed {
        logic [7:0] image_width;
        logic [7:0] image_height;
        logic [5:0] min_radius;
    } cfg_t;

    typedef struct packed {
        logic       hit_valid;
        logic [5:0] radius;
        logic [6:0] center_x;
        logic [6:0] center_y;
        logic       last_result;
        logic       overflow;
        logic [6:0] hit_total;
    } hit_t;

endpackage

// ===== hw/rtl/cd_front.sv =====
module cd_front #(
    parameter int AW    = 14,
    parameter int STORE = 16384
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pixel_valid,
    input  logic          pixel,
    input  logic          last_pixel,
    output logic          pixel_stall,
    input  logic          queue_full,
    output logic          push,
    output logic [AW+1:0] push_data
);
    logic [AW-1:0] pos_reg;

    assign pixel_stall = queue_full;
    assign push        = pixel_valid && !queue_full;
    assign push_data   = {last_pixel, pixel, pos_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (push)
        begin
            if (last_pixel || pos_reg == AW'(STORE - 1))
            begin
                pos_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end
endmodule

// ===== hw/rtl/cd_fifo.sv =====
module cd_fifo #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         not_empty
);
    logic [W-1:0] slot_reg [2];
    logic         wp_reg;
    logic         rp_reg;
    logic [1:0]   count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule

// ===== hw/rtl/cd_back.sv =====
module cd_back #(
    parameter int MAX_SIDE   = 128,
    parameter int MAX_RADIUS = 63,
    parameter int MAX_HITS   = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cd_pkg::cfg_t                   cfg,
    input  logic                           not_empty,
    input  logic [$clog2(MAX_SIDE*MAX_SIDE)+1:0] pop_data,
    output logic                           pop,
    input  logic                           result_stall,
    output logic                           result_valid,
    output cd_pkg::hit_t                   result
);
    import cd_pkg::*;

    localparam int STORE = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(STORE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int XW    = $clog2(MAX_SIDE);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int PW    = $clog2(2 * MAX_RADIUS + 1);
    localparam int DW    = $clog2(2 * MAX_RADIUS + 2);
    localparam int SQW   = 2 * DW;
    localparam int CAPQ  = 2 * MAX_RADIUS + 2;
    localparam int QW    = $clog2(CAPQ + 1);
    localparam int CW    = $clog2(4 * CAPQ + 1);
    localparam int MW    = CW + 5;
    localparam int HW    = $clog2(MAX_HITS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_RAD, S_WALK, S_SQ, S_ROT, S_DRAIN, S_EVAL, S_FIN
    } state_t;

    state_t          state_reg;
    logic            mem [STORE];
    logic            rd_bit_reg;
    logic            pend_reg;
    logic [SW-1:0]   w_reg;
    logic [SW-1:0]   h_reg;
    logic [RW-1:0]   rmax_reg;
    logic [RW-1:0]   r_reg;
    logic [PW-1:0]   r2_reg;
    logic [SQW-1:0]  bound_reg;
    logic [XW-1:0]   xlast_reg;
    logic [XW-1:0]   ylast_reg;
    logic [XW-1:0]   x_reg;
    logic [XW-1:0]   y_reg;
    logic [PW-1:0]   px_reg;
    logic [PW-1:0]   py_reg;
    logic [QW-1:0]   q_reg;
    logic [CW-1:0]   cnt_reg;
    logic [SQW-1:0]  dx2_reg;
    logic [SQW-1:0]  dy2_reg;
    logic [1:0]      idx_reg;
    logic [HW-1:0]   hits_reg;
    logic            over_reg;
    logic            hold_valid_reg;
    hit_t            hold_reg;
    hit_t            res_reg;
    logic            res_valid_reg;

    logic [8:0]      wv;
    logic [8:0]      hv;
    logic [8:0]      wc;
    logic [8:0]      hc;
    logic [8:0]      side;
    logic [8:0]      rmax9;
    logic [8:0]      rmin9;
    logic [8:0]      twor9;
    logic [SQW-1:0]  twor_e;
    logic [DW-1:0]   dxv;
    logic [DW-1:0]   dyv;
    logic [SQW-1:0]  dx_e;
    logic [SQW-1:0]  dy_e;
    logic [SQW:0]    dsum;
    logic [PW-1:0]   tx;
    logic [PW-1:0]   ty;
    logic [AW-1:0]   row_e;
    logic [AW-1:0]   col_e;
    logic [AW-1:0]   w_e;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic [MW-1:0]   lhs;
    logic [MW-1:0]   rhs;
    logic            match;
    logic            take;
    logic            slot_free;
    logic            push_en;
    hit_t            push_data;
    hit_t            new_hit;

    assign pop          = (state_reg == S_IDLE) && not_empty;
    assign wr_addr      = pop_data[AW-1:0];
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        wv = {1'b0, cfg.image_width};
        hv = {1'b0, cfg.image_height};
        if (wv == 9'd0)
            wc = 9'd1;
        else if (wv > 9'(MAX_SIDE))
            wc = 9'(MAX_SIDE);
        else
            wc = wv;
        if (hv == 9'd0)
            hc = 9'd1;
        else if (hv > 9'(MAX_SIDE))
            hc = 9'(MAX_SIDE);
        else
            hc = hv;
        side  = (wc < hc) ? wc : hc;
        rmax9 = (side - 9'd1) >> 1;
        if (rmax9 > 9'(MAX_RADIUS))
            rmax9 = 9'(MAX_RADIUS);
        rmin9 = (cfg.min_radius == 6'd0) ? 9'd1 : {3'b000, cfg.min_radius};

        twor9  = {1'b0, 8'(r_reg)} << 1;
        twor_e = SQW'(twor9);

        dxv  = DW'((DW'(px_reg) - DW'(r_reg)) * 2 + 1);
        dyv  = DW'((DW'(r_reg) - DW'(py_reg)) * 2 - 1);
        dx_e = SQW'(dxv);
        dy_e = SQW'(dyv);
        dsum = {1'b0, dx2_reg} + {1'b0, dy2_reg};

        unique case (idx_reg)
            2'd0:
            begin
                tx = px_reg;
                ty = py_reg;
            end
            2'd1:
            begin
                tx = r2_reg - py_reg;
                ty = px_reg;
            end
            2'd2:
            begin
                tx = r2_reg - px_reg;
                ty = r2_reg - py_reg;
            end
            default:
            begin
                tx = py_reg;
                ty = r2_reg - px_reg;
            end
        endcase
        row_e   = AW'(y_reg) + AW'(ty);
        col_e   = AW'(x_reg) + AW'(tx);
        w_e     = AW'(w_reg);
        rd_addr = row_e * w_e + col_e;

        lhs   = MW'(cnt_reg) * MW'(10);
        rhs   = MW'(q_reg) * MW'(28);
        match = (lhs >= rhs);
        take  = match && (hits_reg < HW'(MAX_HITS));

        new_hit             = '0;
        new_hit.hit_valid   = 1'b1;
        new_hit.radius      = 6'(r_reg);
        new_hit.center_x    = 7'(9'(x_reg) + 9'(r_reg));
        new_hit.center_y    = 7'(9'(y_reg) + 9'(r_reg));

        slot_free = !res_valid_reg || !result_stall;
        push_en   = 1'b0;
        push_data = hold_reg;
        if (state_reg == S_FIN)
        begin
            push_en = slot_free;
            if (hold_valid_reg)
            begin
                push_data.last_result = 1'b1;
                push_data.overflow    = over_reg;
                push_data.hit_total   = 7'(hits_reg);
            end
            else
            begin
                push_data             = '0;
                push_data.last_result = 1'b1;
            end
        end
        else if (state_reg == S_EVAL && take && hold_valid_reg)
        begin
            push_en = slot_free;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mem[wr_addr] <= pop_data[AW];
        end
        rd_bit_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_reg       <= 1'b0;
            hits_reg       <= '0;
            over_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= (state_reg == S_ROT);
            if (push_en)
            begin
                res_reg       <= push_data;
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            if (state_reg == S_WALK)
            begin
                cnt_reg <= '0;
            end
            else if (pend_reg && rd_bit_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop && pop_data[AW+1])
                    begin
                        state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    w_reg          <= SW'(wc);
                    h_reg          <= SW'(hc);
                    rmax_reg       <= RW'(rmax9);
                    r_reg          <= RW'(rmin9);
                    hits_reg       <= '0;
                    over_reg       <= 1'b0;
                    hold_valid_reg <= 1'b0;
                    if (rmin9 > rmax9)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_RAD;
                end
                S_RAD:
                begin
                    xlast_reg <= XW'(9'(w_reg) - 9'd1 - twor9);
                    ylast_reg <= XW'(9'(h_reg) - 9'd1 - twor9);
                    bound_reg <= twor_e * twor_e;
                    r2_reg    <= PW'(twor9);
                    x_reg     <= '0;
                    y_reg     <= '0;
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    px_reg    <= PW'(r_reg);
                    py_reg    <= '0;
                    q_reg     <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    if (py_reg == PW'(r_reg) || q_reg == QW'(CAPQ))
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        dx2_reg   <= dx_e * dx_e;
                        dy2_reg   <= dy_e * dy_e;
                        idx_reg   <= 2'd0;
                        state_reg <= S_ROT;
                    end
                end
                S_ROT:
                begin
                    idx_reg <= idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        if (dsum <= {1'b0, bound_reg})
                            px_reg <= px_reg + 1'b1;
                        if (dsum >= {1'b0, bound_reg})
                            py_reg <= py_reg + 1'b1;
                        q_reg     <= q_reg + 1'b1;
                        state_reg <= S_SQ;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (!(take && hold_valid_reg && !slot_free))
                    begin
                        if (take)
                        begin
                            hold_reg       <= new_hit;
                            hold_valid_reg <= 1'b1;
                            hits_reg       <= hits_reg + 1'b1;
                        end
                        else if (match)
                        begin
                            over_reg <= 1'b1;
                        end
                        if (y_reg != ylast_reg)
                        begin
                            y_reg     <= y_reg + 1'b1;
                            state_reg <= S_WALK;
                        end
                        else if (x_reg != xlast_reg)
                        begin
                            x_reg     <= x_reg + 1'b1;
                            y_reg     <= '0;
                            state_reg <= S_WALK;
                        end
                        else if (r_reg != rmax_reg)
                        begin
                            r_reg     <= r_reg + 1'b1;
                            state_reg <= S_RAD;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_FIN:
                begin
                    if (slot_free)
                    begin
                        hold_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== hw/rtl/binary_image_circle_detector.sv =====
// Pixels load at one transaction per cycle while no search is running.
// The search starts once the last pixel is stored; for each radius and each offset it walks
// one quarter arc and reads the image store at four rotated points per arc point. The store
// has a single read port, so these reads go one at a time; results follow in search order.
// Reset clears control state and restores the register defaults; the image store is not cleared.
module binary_image_circle_detector #(
    parameter int MAX_SIDE   = 128,
    parameter int MAX_RADIUS = 63,
    parameter int MAX_HITS   = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pixel_valid,
    output logic       pixel_stall,
    input  logic       pixel,
    input  logic       last_pixel,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       hit_valid,
    output logic [5:0] radius,
    output logic [6:0] center_x,
    output logic [6:0] center_y,
    output logic       last_result,
    output logic       overflow,
    output logic [6:0] hit_total,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import cd_pkg::*;

    localparam int STORE = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(STORE);

    cfg_t            cfg_reg;
    logic            q_full;
    logic            q_push;
    logic [AW+1:0]   q_push_data;
    logic            q_pop;
    logic [AW+1:0]   q_pop_data;
    logic            q_not_empty;
    hit_t            res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= WIDTH_RESET;
            cfg_reg.image_height <= HEIGHT_RESET;
            cfg_reg.min_radius   <= MIN_R_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data;
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data;
                REG_MIN_RADIUS:   cfg_reg.min_radius   <= cfg_data[5:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    cd_front #(
        .AW    (AW),
        .STORE (STORE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel       (pixel),
        .last_pixel  (last_pixel),
        .pixel_stall (pixel_stall),
        .queue_full  (q_full),
        .push        (q_push),
        .push_data   (q_push_data)
    );

    cd_fifo #(
        .W (AW + 2)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty)
    );

    cd_back #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_HITS   (MAX_HITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .not_empty    (q_not_empty),
        .pop_data     (q_pop_data),
        .pop          (q_pop),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (res)
    );

    assign hit_valid   = res.hit_valid;
    assign radius      = res.radius;
    assign center_x    = res.center_x;
    assign center_y    = res.center_y;
    assign last_result = res.last_result;
    assign overflow    = res.overflow;
    assign hit_total   = res.hit_total;

    a_totals_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_result |-> hit_total == 7'd0 && !overflow)
        else $error("totals shown on a non-final result");

    a_total_capped: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> hit_total <= 7'(MAX_HITS))
        else $error("hit total above cap");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && overflow |-> hit_total == 7'(MAX_HITS))
        else $error("overflow flagged below cap");
endmodule
